// ===== hw/rtl/nmb_pkg.sv =====
// ----------------------------------------------------------------------------
// NDEF message builder package
// Shared types and constants for the NDEF message builder and its checker.
// ----------------------------------------------------------------------------
package nmb_pkg;

  localparam int BUFFER_BYTES_DEF = 1024;
  localparam int BLOCK_BYTES_DEF  = 16;

  localparam int READ_ADDR_W = 10;
  localparam int PLEN_W      = 10;
  localparam int MSG_LEN_W   = 11;
  localparam int BLK_CNT_W   = 7;
  localparam int ENC_W       = 16;

  localparam int CLEAR_BYTES    = 3;
  localparam int TLV_HDR_BYTES  = 4;
  localparam int ROOM_FIXED     = TLV_HDR_BYTES + 1;
  localparam int REC_HEAD_SHORT = 4;
  localparam int REC_HEAD_LONG  = 7;

  localparam logic [7:0] TLV_NDEF       = 8'h03;
  localparam logic [7:0] TLV_END        = 8'hFE;
  localparam logic [7:0] TLV_LEN_EMPTY  = 8'h00;
  localparam logic [7:0] TLV_LEN_LONG   = 8'hFF;
  localparam logic [7:0] HDR_BEGIN      = 8'h80;
  localparam logic [7:0] HDR_END        = 8'h40;
  localparam logic [7:0] HDR_SHORT      = 8'h10;
  localparam logic [7:0] TNF_WELL_KNOWN = 8'h01;
  localparam logic [7:0] TYPE_LEN_ONE   = 8'h01;
  localparam logic [7:0] SHORT_MAX      = 8'hFF;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_START   = 2'd1,
    OP_PAYLOAD = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_ROOM = 2'd1,
    STAT_SEQ     = 2'd2,
    STAT_ADDR    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_RMW_RD,
    S_RMW_WR,
    S_TLV,
    S_REC,
    S_PAY,
    S_READ,
    S_FIN
  } state_t;

  typedef struct packed {
    op_t                    operation;
    logic [7:0]             record_type;
    logic [PLEN_W-1:0]      pay_len;
    logic [7:0]             data_byte;
    logic [READ_ADDR_W-1:0] read_address;
  } in_t;

  typedef struct packed {
    logic [7:0]           read_data;
    status_t              status;
    logic [MSG_LEN_W-1:0] message_length;
    logic [BLK_CNT_W-1:0] block_count;
  } out_t;

endpackage

// ===== hw/rtl/ndef_message_builder.sv =====
// ----------------------------------------------------------------------------
// NDEF message builder
// Builds a TLV-framed NDEF message in an internal byte store and reads it back.
// ----------------------------------------------------------------------------
// The message lives in a single-port-write, single-port-read byte memory, and
// every stored byte takes its own write on its write port. A clear writes the
// three empty-message bytes; a start record does a read-modify-write of the
// previous header when there is one, writes three TLV length bytes, then four
// to seven record bytes; a payload byte writes the byte and, after the last one,
// the terminator; a read fetches one byte; a rejected item goes straight to its
// result. A new item is accepted once the previous one has moved its result into
// the output register, while that result may still be waiting to be taken. The store needs no clearing after reset.
module ndef_message_builder import nmb_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int BLOCK_BYTES  = BLOCK_BYTES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int AW     = $clog2(BUFFER_BYTES);
  localparam int WIW    = $clog2(BUFFER_BYTES + 1);
  localparam int FW     = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
  localparam int CW     = (WIW > READ_ADDR_W) ? WIW : READ_ADDR_W;
  localparam int LW     = (WIW > MSG_LEN_W) ? WIW : MSG_LEN_W;
  localparam int BW     = (WIW > BLK_CNT_W) ? WIW : BLK_CNT_W;
  localparam int ROOM_W = ENC_W + 2;
  localparam int CLR_BLK  = (CLEAR_BYTES + BLOCK_BYTES - 1) / BLOCK_BYTES;
  localparam int CLR_FILL = CLEAR_BYTES % BLOCK_BYTES;

  logic [7:0] mem [BUFFER_BYTES];

  state_t            state_r, state_nxt;
  in_t               cmd_r, cmd_nxt;
  status_t           stat_r, stat_nxt;
  logic [WIW-1:0]    wi_r, wi_nxt;
  logic [WIW-1:0]    blk_r, blk_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic [ENC_W-1:0]  enc_r, enc_nxt;
  logic [AW-1:0]     lhi_r, lhi_nxt;
  logic [PLEN_W-1:0] prem_r, prem_nxt;
  logic              open_r, open_nxt;
  logic              first_r, first_nxt;
  logic              short_r, short_nxt;
  logic [AW-1:0]     wp_r, wp_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [7:0]        rd_data_r;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  logic              in_fire;
  logic              out_load;
  logic              seq_err;
  logic              room_err;
  logic              in_short;
  logic [ROOM_W-1:0] room_need;
  logic [ENC_W-1:0]  enc_new;
  logic [CW-1:0]     addr_ext;
  logic              rd_ok;
  logic              we;
  logic [AW-1:0]     wa;
  logic [7:0]        wd;
  logic              re;
  logic [AW-1:0]     ra;
  logic              wi_hit;
  logic [7:0]        hdr_byte;
  logic [7:0]        rec_byte;
  logic [2:0]        rec_last;
  logic [LW-1:0]     wi_ext;
  logic [BW-1:0]     blk_ext;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_load  = (state_r == S_FIN) && (!out_valid_r || out_ready);

  assign in_short  = (in_data.pay_len <= PLEN_W'(SHORT_MAX));
  assign seq_err   = (wi_r == '0) || open_r;
  assign room_need = ROOM_W'(ROOM_FIXED) + ROOM_W'(enc_r)
                   + ROOM_W'(in_short ? REC_HEAD_SHORT : REC_HEAD_LONG)
                   + ROOM_W'(in_data.pay_len);
  assign room_err  = room_need > ROOM_W'(BUFFER_BYTES);
  assign enc_new   = ENC_W'(room_need - ROOM_W'(ROOM_FIXED));
  assign addr_ext  = CW'(in_data.read_address);
  assign rd_ok     = addr_ext < CW'(wi_r);

  assign hdr_byte = TNF_WELL_KNOWN | HDR_END | (first_r ? HDR_BEGIN : 8'h00)
                  | (short_r ? HDR_SHORT : 8'h00);

  always_comb begin
    if (short_r) begin
      rec_last = (cmd_r.pay_len == '0) ? 3'd4 : 3'd3;
      unique case (cnt_r)
        3'd0:    rec_byte = hdr_byte;
        3'd1:    rec_byte = TYPE_LEN_ONE;
        3'd2:    rec_byte = cmd_r.pay_len[7:0];
        3'd3:    rec_byte = cmd_r.record_type;
        default: rec_byte = TLV_END;
      endcase
    end else begin
      rec_last = 3'd6;
      unique case (cnt_r)
        3'd0:    rec_byte = hdr_byte;
        3'd1:    rec_byte = TYPE_LEN_ONE;
        3'd4:    rec_byte = 8'(cmd_r.pay_len[PLEN_W-1:8]);
        3'd5:    rec_byte = cmd_r.pay_len[7:0];
        3'd6:    rec_byte = cmd_r.record_type;
        default: rec_byte = 8'h00;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_data.operation)
            OP_CLEAR: state_nxt = S_CLEAR;
            OP_START: begin
              if (seq_err || room_err) begin
                state_nxt = S_FIN;
              end else if (lhi_r != '0) begin
                state_nxt = S_RMW_RD;
              end else begin
                state_nxt = S_TLV;
              end
            end
            OP_PAYLOAD: state_nxt = open_r ? S_PAY : S_FIN;
            OP_READ:    state_nxt = rd_ok ? S_READ : S_FIN;
          endcase
        end
      end
      S_CLEAR:  if (cnt_r == 3'd2) state_nxt = S_FIN;
      S_RMW_RD: state_nxt = S_RMW_WR;
      S_RMW_WR: state_nxt = S_TLV;
      S_TLV:    if (cnt_r == 3'd2) state_nxt = S_REC;
      S_REC:    if (cnt_r == rec_last) state_nxt = S_FIN;
      S_PAY: begin
        if (cnt_r != 3'd0 || prem_r != PLEN_W'(1)) begin
          state_nxt = S_FIN;
        end
      end
      S_READ:   state_nxt = S_FIN;
      S_FIN:    if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = 8'h00;
    re = 1'b0;
    ra = '0;
    unique case (state_r)
      S_IDLE: begin
        re = in_fire && (in_data.operation == OP_READ) && rd_ok;
        ra = addr_ext[AW-1:0];
      end
      S_CLEAR: begin
        we = 1'b1;
        wa = AW'(cnt_r);
        unique case (cnt_r)
          3'd0:    wd = TLV_NDEF;
          3'd1:    wd = TLV_LEN_EMPTY;
          default: wd = TLV_END;
        endcase
      end
      S_RMW_RD: begin
        re = 1'b1;
        ra = lhi_r;
      end
      S_RMW_WR: begin
        we = 1'b1;
        wa = lhi_r;
        wd = rd_data_r & ~HDR_END;
      end
      S_TLV: begin
        we = 1'b1;
        wa = AW'(cnt_r) + AW'(1);
        unique case (cnt_r)
          3'd0:    wd = TLV_LEN_LONG;
          3'd1:    wd = enc_r[15:8];
          default: wd = enc_r[7:0];
        endcase
      end
      S_REC: begin
        we = 1'b1;
        wa = wp_r;
        wd = rec_byte;
      end
      S_PAY: begin
        we = 1'b1;
        wa = wi_r[AW-1:0];
        wd = (cnt_r == 3'd0) ? cmd_r.data_byte : TLV_END;
      end
      default: begin
      end
    endcase
  end

  assign wi_hit = we && (state_r != S_CLEAR) && (WIW'(wa) == wi_r);

  always_comb begin
    cmd_nxt       = cmd_r;
    stat_nxt      = stat_r;
    wi_nxt        = wi_r;
    blk_nxt       = blk_r;
    fill_nxt      = fill_r;
    enc_nxt       = enc_r;
    lhi_nxt       = lhi_r;
    prem_nxt      = prem_r;
    open_nxt      = open_r;
    first_nxt     = first_r;
    short_nxt     = short_r;
    wp_nxt        = wp_r;
    cnt_nxt       = (state_nxt != state_r) ? 3'd0 : cnt_r + 3'd1;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (in_fire) begin
      cmd_nxt  = in_data;
      stat_nxt = STAT_OK;
      unique case (in_data.operation)
        OP_CLEAR: begin
          enc_nxt  = '0;
          lhi_nxt  = '0;
          prem_nxt = '0;
          open_nxt = 1'b0;
        end
        OP_START: begin
          if (seq_err) begin
            stat_nxt = STAT_SEQ;
          end else if (room_err) begin
            stat_nxt = STAT_NO_ROOM;
          end else begin
            enc_nxt   = enc_new;
            first_nxt = (enc_r == '0);
            short_nxt = in_short;
            wp_nxt    = (enc_r == '0) ? AW'(TLV_HDR_BYTES) : AW'(wi_r - WIW'(1));
          end
        end
        OP_PAYLOAD: if (!open_r) stat_nxt = STAT_SEQ;
        OP_READ:    if (!rd_ok) stat_nxt = STAT_ADDR;
      endcase
    end

    if (state_r == S_REC) begin
      wp_nxt = wp_r + AW'(1);
      if (cnt_r == 3'd0) begin
        lhi_nxt = wp_r;
      end
      if (cnt_r == rec_last) begin
        prem_nxt = cmd_r.pay_len;
        open_nxt = (cmd_r.pay_len != '0);
      end
    end

    if (state_r == S_PAY && cnt_r == 3'd0) begin
      prem_nxt = prem_r - PLEN_W'(1);
      if (prem_r == PLEN_W'(1)) begin
        open_nxt = 1'b0;
      end
    end

    if (state_r == S_CLEAR && cnt_r == 3'd2) begin
      wi_nxt   = WIW'(CLEAR_BYTES);
      blk_nxt  = WIW'(CLR_BLK);
      fill_nxt = FW'(CLR_FILL);
    end else if (wi_hit) begin
      wi_nxt   = wi_r + WIW'(1);
      blk_nxt  = (fill_r == '0) ? blk_r + WIW'(1) : blk_r;
      fill_nxt = (fill_r == FW'(BLOCK_BYTES - 1)) ? '0 : fill_r + FW'(1);
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.read_data      = (cmd_r.operation == OP_READ && stat_r == STAT_OK)
                                    ? rd_data_r : 8'h00;
      out_data_nxt.status         = stat_r;
      out_data_nxt.message_length = wi_ext[MSG_LEN_W-1:0];
      out_data_nxt.block_count    = blk_ext[BLK_CNT_W-1:0];
    end
  end

  assign wi_ext  = LW'(wi_r);
  assign blk_ext = BW'(blk_r);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data_r <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wi_r        <= '0;
      blk_r       <= '0;
      fill_r      <= '0;
      enc_r       <= '0;
      lhi_r       <= '0;
      prem_r      <= '0;
      open_r      <= 1'b0;
      cnt_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wi_r        <= wi_nxt;
      blk_r       <= blk_nxt;
      fill_r      <= fill_nxt;
      enc_r       <= enc_nxt;
      lhi_r       <= lhi_nxt;
      prem_r      <= prem_nxt;
      open_r      <= open_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    stat_r     <= stat_nxt;
    first_r    <= first_nxt;
    short_r    <= short_nxt;
    wp_r       <= wp_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== hw/rtl/nmb_checker.sv =====
// ----------------------------------------------------------------------------
// NDEF message builder checker
// Port-level properties of the NDEF message builder, bound to its top level.
// ----------------------------------------------------------------------------
module nmb_checker import nmb_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result changed or dropped.");

  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STAT_OK |-> out_data.read_data == 8'h00)
    else $error("Failed item returned nonzero read data.");

  a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.message_length != MSG_LEN_W'(1)
               && out_data.message_length != MSG_LEN_W'(2))
    else $error("Message length cannot be one or two bytes.");

  a_blk_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.message_length == '0) == (out_data.block_count == '0))
    else $error("Block count disagrees with an empty message.");

  a_no_msg_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.message_length == '0 |-> out_data.status != STAT_OK
               || $past(out_valid))
    else $error("Operation succeeded without a message.");

endmodule

bind ndef_message_builder nmb_checker u_nmb_checker (.*);

// ===== tb/tb_ndef_message_builder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NDEF message builder testbench
// Drives clear, start record, payload and read items through the valid/ready
// channels, predicts every result with a byte-level model of the TLV message
// and compares each returned item field by field under varying back-pressure.
// ----------------------------------------------------------------------------
import nmb_pkg::*;

class ndef_scoreboard;
  logic [7:0]  msg_mem [BUFFER_BYTES_DEF];
  int unsigned wr_idx;
  int unsigned enc_size;
  int unsigned last_hdr;
  int unsigned pay_left;
  bit          rec_open;
  out_t        expected_q[$];
  int unsigned errors;

  function new();
    wr_idx   = 0;
    enc_size = 0;
    last_hdr = 0;
    pay_left = 0;
    rec_open = 1'b0;
    errors   = 0;
  endfunction

  function void append_byte(logic [7:0] v);
    if (wr_idx < BUFFER_BYTES_DEF) msg_mem[wr_idx] = v;
    wr_idx++;
  endfunction

  function status_t open_record(logic [7:0] rtype, logic [PLEN_W-1:0] plen);
    bit          is_short;
    int unsigned head;
    logic [7:0]  hdr;
    is_short = (plen <= SHORT_MAX);
    head = is_short ? REC_HEAD_SHORT : REC_HEAD_LONG;
    if (wr_idx == 0 || rec_open) return STAT_SEQ;
    if (ROOM_FIXED + enc_size + head + plen > BUFFER_BYTES_DEF) return STAT_NO_ROOM;
    if (last_hdr != 0) msg_mem[last_hdr] = msg_mem[last_hdr] & ~HDR_END;
    if (enc_size == 0) begin
      msg_mem[1] = TLV_LEN_LONG;
      wr_idx = TLV_HDR_BYTES;
    end else begin
      wr_idx--;
    end
    enc_size = (enc_size + head + plen) & 32'h0000_FFFF;
    msg_mem[2] = enc_size[15:8];
    msg_mem[3] = enc_size[7:0];
    hdr = TNF_WELL_KNOWN | HDR_END;
    if (wr_idx == TLV_HDR_BYTES) hdr = hdr | HDR_BEGIN;
    if (is_short) hdr = hdr | HDR_SHORT;
    last_hdr = wr_idx;
    append_byte(hdr);
    append_byte(TYPE_LEN_ONE);
    if (is_short) begin
      append_byte(plen[7:0]);
    end else begin
      append_byte(8'h00);
      append_byte(8'h00);
      append_byte(8'(plen >> 8));
      append_byte(plen[7:0]);
    end
    append_byte(rtype);
    pay_left = plen;
    if (plen == 0) begin
      append_byte(TLV_END);
      rec_open = 1'b0;
    end else begin
      rec_open = 1'b1;
    end
    return STAT_OK;
  endfunction

  function void note_input(in_t x);
    out_t r;
    r = '0;
    r.status = STAT_OK;
    case (x.operation)
      OP_CLEAR: begin
        msg_mem[0] = TLV_NDEF;
        msg_mem[1] = TLV_LEN_EMPTY;
        msg_mem[2] = TLV_END;
        wr_idx   = CLEAR_BYTES;
        enc_size = 0;
        last_hdr = 0;
        pay_left = 0;
        rec_open = 1'b0;
      end
      OP_START: begin
        r.status = open_record(x.record_type, x.pay_len);
      end
      OP_PAYLOAD: begin
        if (!rec_open || pay_left == 0) begin
          r.status = STAT_SEQ;
        end else begin
          append_byte(x.data_byte);
          pay_left--;
          if (pay_left == 0) begin
            append_byte(TLV_END);
            rec_open = 1'b0;
          end
        end
      end
      default: begin
        if (x.read_address < wr_idx) r.read_data = msg_mem[x.read_address];
        else r.status = STAT_ADDR;
      end
    endcase
    r.message_length = MSG_LEN_W'(wr_idx);
    r.block_count = BLK_CNT_W'((wr_idx + BLOCK_BYTES_DEF - 1) / BLOCK_BYTES_DEF);
    expected_q.push_back(r);
  endfunction

  function void check_result(out_t got);
    out_t exp_r;
    if (expected_q.size() == 0) begin
      $error("result item arrived with no item outstanding");
      errors++;
      return;
    end
    exp_r = expected_q.pop_front();
    if (got.read_data !== exp_r.read_data) begin
      $error("read_data: expected %0d, got %0d", exp_r.read_data, got.read_data);
      errors++;
    end
    if (got.status !== exp_r.status) begin
      $error("status: expected %0d, got %0d", exp_r.status, got.status);
      errors++;
    end
    if (got.message_length !== exp_r.message_length) begin
      $error("message_length: expected %0d, got %0d", exp_r.message_length,
             got.message_length);
      errors++;
    end
    if (got.block_count !== exp_r.block_count) begin
      $error("block_count: expected %0d, got %0d", exp_r.block_count, got.block_count);
      errors++;
    end
  endfunction

  function int outstanding();
    return expected_q.size();
  endfunction
endclass

module tb_ndef_message_builder;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int ITEM_TARGET = 750;

  localparam logic [7:0] TYPE_TEXT = 8'h54;
  localparam logic [7:0] TYPE_URI  = 8'h55;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  ndef_scoreboard sb;
  int unsigned    items_sent;
  int unsigned    in_idle_pct;
  int unsigned    out_stall_pct;
  int unsigned    idle_cycles;

  ndef_message_builder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic in_t make_item(op_t op);
    in_t x;
    x.operation    = op;
    x.record_type  = 8'($urandom);
    x.pay_len      = PLEN_W'($urandom);
    x.data_byte    = 8'($urandom);
    x.read_address = READ_ADDR_W'($urandom);
    return x;
  endfunction

  task automatic push_item(in_t x);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic clear_message();
    push_item(make_item(OP_CLEAR));
  endtask

  task automatic start_record(logic [7:0] rtype, int unsigned plen);
    in_t x;
    x = make_item(OP_START);
    x.record_type = rtype;
    x.pay_len     = PLEN_W'(plen);
    push_item(x);
  endtask

  task automatic push_byte(logic [7:0] d);
    in_t x;
    x = make_item(OP_PAYLOAD);
    x.data_byte = d;
    push_item(x);
  endtask

  task automatic read_byte(int unsigned addr);
    in_t x;
    x = make_item(OP_READ);
    x.read_address = READ_ADDR_W'(addr);
    push_item(x);
  endtask

  task automatic build_message(int unsigned stop_at);
    int unsigned nrec;
    int unsigned plen;
    int unsigned nbytes;
    int unsigned r;
    logic [7:0]  rtype;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 4)) push_item(make_item(op_t'($urandom_range(3))));
    end
    clear_message();
    nrec = $urandom_range(1, 5);
    for (int i = 0; i < nrec; i++) begin
      r = $urandom_range(99);
      if (r < 60) plen = $urandom_range(0, 12);
      else if (r < 80) plen = $urandom_range(13, 80);
      else if (r < 86) plen = $urandom_range(81, 255);
      else if (r < 92) plen = $urandom_range(256, 300);
      else plen = $urandom_range(301, 1023);
      if ($urandom_range(1)) rtype = $urandom_range(1) ? TYPE_TEXT : TYPE_URI;
      else rtype = 8'($urandom);
      start_record(rtype, plen);
      if (!sb.rec_open) continue;
      nbytes = (plen > 300) ? $urandom_range(0, 20) : plen;
      for (int b = 0; b < nbytes; b++) begin
        if (items_sent >= stop_at) break;
        r = $urandom_range(99);
        if (r < 8) read_byte($urandom_range(0, sb.wr_idx - 1));
        else if (r < 10) start_record(8'($urandom), $urandom_range(0, 1023));
        push_byte(8'($urandom));
      end
      if (sb.rec_open) begin
        clear_message();
        break;
      end
    end
    repeat ($urandom_range(2, 6)) read_byte($urandom_range(0, sb.wr_idx - 1));
    if (sb.wr_idx <= 1023) read_byte($urandom_range(sb.wr_idx, 1023));
  endtask

  initial begin
    int unsigned idle_in  [4];
    int unsigned stall_out[4];
    idle_in   = '{0, 87, 0, 21};
    stall_out = '{0, 0, 87, 21};
    sb = new();
    items_sent    = 0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Nothing is built yet, so writes are out of sequence and reads miss.
    start_record(TYPE_TEXT, 5);
    push_byte(8'h11);
    read_byte(0);
    clear_message();
    read_byte(2);
    read_byte(3);
    push_byte(8'h22);
    // An empty record closes at once; a second record is then left open.
    start_record(TYPE_TEXT, 0);
    start_record(TYPE_URI, 2);
    start_record(TYPE_TEXT, 1);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h33);
    read_byte(1023);
    read_byte(4);
    read_byte(8);
    read_byte(3);
    read_byte(14);
    start_record(8'hFF, 1023);
    start_record(8'h00, 300);
    push_byte(8'hA5);
    read_byte(16);
    clear_message();
    read_byte(0);
    // A completed long record loses its end flag when the next record starts.
    start_record(TYPE_URI, 256);
    repeat (256) push_byte(8'($urandom));
    start_record(TYPE_TEXT, 1);
    push_byte(8'h44);
    read_byte(4);
    read_byte(266);

    for (int p = 0; p < 4; p++) begin
      in_idle_pct   = idle_in[p];
      out_stall_pct = stall_out[p];
      while (items_sent < ITEM_TARGET * (p + 1) / 4) begin
        build_message(ITEM_TARGET * (p + 1) / 4);
      end
    end
    in_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
